>>> sv/wildcard_glob_match_unit_macros.svh
// Assertion macros for the glob matcher.
// Each checker samples on clk and is muted while rst_n is low.
`ifndef WILDCARD_GLOB_MATCH_UNIT_MACROS_SVH
`define WILDCARD_GLOB_MATCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define WGM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wgm check failed");

// Next-cycle implication.
`define WGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wgm check failed");

`else

`define WGM_ASSERT_NOW(label, ante, cons)
`define WGM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/wgm_pkg.sv
package wgm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int ACT_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CLOSE_LVLS  = $clog2(ACT_W);

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // active set with only position zero live
  localparam logic [ACT_W-1:0] ARMED = ACT_W'(1);

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SOURCE = 2'd2,
    REQ_END    = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t  req_type;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  // Per-position view of the loaded pattern for the current symbol.
  typedef struct packed {
    logic [PATTERN_MAX-1:0] star;  // star at position, within length
    logic [PATTERN_MAX-1:0] hit;   // '?' or equal byte, within length
    logic [LEN_W-1:0]       len;
    logic                   too_long;
  } pat_view_t;

  // Forward fill of active positions through runs of stars:
  // c[j] = a[j] | (star[j-1] & c[j-1]). Parallel prefix, log depth.
  function automatic logic [ACT_W-1:0] star_close(input logic [ACT_W-1:0]       a,
                                                  input logic [PATTERN_MAX-1:0] star);
    logic [ACT_W-1:0] g;
    logic [ACT_W-1:0] p;
    logic [ACT_W-1:0] ng;
    logic [ACT_W-1:0] np;
    int               d;
    g = a;
    p = {star, 1'b0};
    for (int lv = 0; lv < CLOSE_LVLS; lv++) begin
      d  = 1 << lv;
      ng = g;
      np = p;
      for (int j = 0; j < ACT_W; j++) begin
        if (j >= d) begin
          ng[j] = g[j] | (p[j] & g[j-d]);
          np[j] = p[j] & p[j-d];
        end
      end
      g = ng;
      p = np;
    end
    return g;
  endfunction

endpackage

>>> sv/wgm_pat_store.sv
module wgm_pat_store
  import wgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  in_item_t   item,
  output pat_view_t  view
);

  logic [7:0]       pat_r [PATTERN_MAX];
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             too_long_r;
  logic             too_long_nxt;
  logic             full;
  logic             wr_en;

  assign full  = (len_r >= LEN_W'(PATTERN_MAX));
  assign wr_en = go && (item.req_type == REQ_APPEND) && !full;

  always_comb begin
    len_nxt      = len_r;
    too_long_nxt = too_long_r;
    if (go) begin
      case (item.req_type)
        REQ_BEGIN: begin
          len_nxt      = '0;
          too_long_nxt = 1'b0;
        end
        REQ_APPEND: begin
          if (full) begin
            too_long_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      too_long_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      too_long_r <= too_long_nxt;
    end
  end

  // pattern bytes: no reset, only positions below len_r are looked at
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r[len_r[IDX_W-1:0]] <= item.symbol;
    end
  end

  always_comb begin
    view.len      = len_r;
    view.too_long = too_long_r;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      view.star[i] = (LEN_W'(i) < len_r) && (pat_r[i] == CH_STAR);
      view.hit[i]  = (LEN_W'(i) < len_r) &&
                     ((pat_r[i] == CH_QMARK) || (pat_r[i] == item.symbol));
    end
  end

endmodule

>>> sv/wgm_nfa.sv
module wgm_nfa
  import wgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  req_type_t  req_type,
  input  pat_view_t  view,
  output logic       matched
);

  logic [ACT_W-1:0] act_r;
  logic [ACT_W-1:0] act_nxt;
  logic [ACT_W-1:0] closed;
  logic [ACT_W-1:0] adv;

  assign closed = star_close(act_r, view.star);

  // star keeps its position and moves on; '?' or equal byte moves on
  assign adv = {closed[PATTERN_MAX-1:0] & (view.star | view.hit), 1'b0} |
               {1'b0, closed[PATTERN_MAX-1:0] & view.star};

  assign matched = !view.too_long && closed[view.len];

  always_comb begin
    act_nxt = act_r;
    if (go) begin
      case (req_type)
        REQ_SOURCE: act_nxt = adv;
        default:    act_nxt = ARMED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ARMED;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

>>> sv/wildcard_glob_match_unit.sv
// Glob matcher with '*' and '?' wildcards, one item per cycle unless the input stalls.
// Each taken item is held in the input register and processed from there; an end item's verdict
// is written to the result register and stays on out_valid until it is taken.
// Throughput: one item per cycle (combinational star fill prefix, per-position compare);
// the input stalls only while an end item waits behind a full, stalled result register.
// Reset (rst_n low, synchronous): empty pattern, overflow cleared, position zero armed.
`include "wildcard_glob_match_unit_macros.svh"

module wildcard_glob_match_unit
  import wgm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // input register
  logic      s1_v_r;
  logic      s1_v_nxt;
  in_item_t  s1_item_r;

  // result register
  logic      out_v_r;
  logic      out_v_nxt;
  out_item_t out_item_r;

  logic      s1_is_end;
  logic      s1_ok;     // stage 1 may retire its transaction this cycle
  logic      s1_go;
  logic      in_take;
  logic      hit;
  pat_view_t view;

  assign s1_is_end = (s1_item_r.req_type == REQ_END);
  // only an end item needs room in the result register
  assign s1_ok     = !s1_is_end || !out_v_r || !out_stall;
  assign s1_go     = s1_v_r && s1_ok;
  assign in_stall  = s1_v_r && !s1_ok;
  assign in_take   = in_valid && !in_stall;

  wgm_pat_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (s1_item_r),
    .view  (view)
  );

  wgm_nfa u_nfa (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_go),
    .req_type (s1_item_r.req_type),
    .view     (view),
    .matched  (hit)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_go && s1_is_end) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_go && s1_is_end) begin
      out_item_r.matched  <= hit;
      out_item_r.overflow <= view.too_long;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // input backs up only behind a blocked result
  `WGM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall && s1_is_end)
  // a retired end transaction always lands in the result register
  `WGM_ASSERT_NEXT(a_end_lands, s1_go && s1_is_end, out_valid)
  // an overflowed pattern never reports a match
  `WGM_ASSERT_NOW(a_ovf_no_match, out_valid && out_item.overflow, !out_item.matched)

endmodule
